>>> rtl/core/nsrp_pkg.sv
// Package for the NDEF short record text parser: request and result types,
// status codes, header constants and the text/plain type table.
// No dependencies.
package nsrp_pkg;

    localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
    localparam logic [2:0] TNF_MEDIA      = 3'd2;
    localparam logic [7:0] MEDIA_TYPE_LEN = 8'h0A;
    localparam logic [7:0] TEXT_TYPE_CHAR = 8'h54;
    localparam logic [7:0] PAD_BYTE       = 8'h00;

    localparam int unsigned HDR_IL_BIT = 3;
    localparam int unsigned HDR_SR_BIT = 4;
    localparam int unsigned HDR_ME_BIT = 6;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_TNF  = 3'd2,
        ST_LONG     = 3'd3,
        ST_BAD_TYPE = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
        logic       message_end;
        logic [7:0] payload_length;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic    fire;
        result_t data;
    } res_ctl_t;

    function automatic logic [7:0] media_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h74;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h78;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h2F;
            4'd5:    c = 8'h70;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h61;
            4'd8:    c = 8'h69;
            4'd9:    c = 8'h6E;
            default: c = PAD_BYTE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/nsrp_in_stage.sv
// Input register of the NDEF short record text parser.
// Holds one request until the result slot can take its outcome.
// Depends on nsrp_pkg.
module nsrp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  nsrp_pkg::item_t item,
    input  logic           slot_free,
    output logic           advance,
    output nsrp_pkg::item_t held
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    nsrp_pkg::item_t hold_item_reg;

    assign advance    = hold_valid_reg && slot_free;
    assign item_ready = !hold_valid_reg || advance;
    assign held       = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (item_ready)
        begin
            hold_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            hold_item_reg <= item;
        end
    end

endmodule

>>> rtl/core/nsrp_parser.sv
// Record parse state machine of the NDEF short record text parser.
// Tracks header fields and lengths, checks the type, and forms results.
// Depends on nsrp_pkg.
module nsrp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  nsrp_pkg::item_t   held,
    output nsrp_pkg::res_ctl_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPELEN,
        PH_PAYLEN,
        PH_IDLEN,
        PH_TYPE,
        PH_ID,
        PH_PAYLOAD
    } phase_t;

    phase_t     phase_reg,       phase_next;
    logic [2:0] tnf_reg,         tnf_next;
    logic       id_present_reg,  id_present_next;
    logic       end_flag_reg,    end_flag_next;
    logic [7:0] type_len_reg,    type_len_next;
    logic [7:0] pay_len_reg,     pay_len_next;
    logic [7:0] id_len_reg,      id_len_next;
    logic [7:0] count_reg,       count_next;
    logic       type_ok_reg,     type_ok_next;

    logic [7:0]        b;
    logic [8:0]        count_inc;
    logic [7:0]        want;
    logic              type_ok_now;
    logic              fire;
    logic              last;
    logic [7:0]        out_byte;
    nsrp_pkg::status_t status;

    assign b         = held.data_byte;
    assign count_inc = {1'b0, count_reg} + 9'd1;

    always_comb
    begin
        if (tnf_reg == nsrp_pkg::TNF_MEDIA)
        begin
            want = (count_reg < 8'd10) ? nsrp_pkg::media_char(count_reg[3:0])
                                       : nsrp_pkg::PAD_BYTE;
        end
        else
        begin
            want = (count_inc < {1'b0, type_len_reg}) ? nsrp_pkg::PAD_BYTE
                                                      : nsrp_pkg::TEXT_TYPE_CHAR;
        end
    end

    assign type_ok_now = type_ok_reg && (b == want);

    always_comb
    begin
        phase_next      = phase_reg;
        tnf_next        = tnf_reg;
        id_present_next = id_present_reg;
        end_flag_next   = end_flag_reg;
        type_len_next   = type_len_reg;
        pay_len_next    = pay_len_reg;
        id_len_next     = id_len_reg;
        count_next      = count_reg;
        type_ok_next    = type_ok_reg;
        fire            = 1'b0;
        last            = 1'b1;
        out_byte        = 8'h00;
        status          = nsrp_pkg::ST_DATA;

        if (held.record_start)
        begin
            tnf_next        = b[2:0];
            id_present_next = b[nsrp_pkg::HDR_IL_BIT];
            end_flag_next   = b[nsrp_pkg::HDR_ME_BIT];
            type_len_next   = 8'h00;
            pay_len_next    = 8'h00;
            id_len_next     = 8'h00;
            count_next      = 8'h00;
            type_ok_next    = 1'b1;
            phase_next      = PH_IDLE;
            if (b[2:0] != nsrp_pkg::TNF_WELL_KNOWN && b[2:0] != nsrp_pkg::TNF_MEDIA)
            begin
                fire   = 1'b1;
                status = nsrp_pkg::ST_BAD_TNF;
            end
            else if (!b[nsrp_pkg::HDR_SR_BIT])
            begin
                fire   = 1'b1;
                status = nsrp_pkg::ST_LONG;
            end
            else
            begin
                phase_next = PH_TYPELEN;
            end
        end
        else
        begin
            case (phase_reg)
                PH_TYPELEN:
                begin
                    type_len_next = b;
                    if (b == 8'h00 ||
                        (tnf_reg == nsrp_pkg::TNF_MEDIA && b != nsrp_pkg::MEDIA_TYPE_LEN))
                    begin
                        phase_next = PH_IDLE;
                        fire       = 1'b1;
                        status     = nsrp_pkg::ST_BAD_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_PAYLEN;
                    end
                end
                PH_PAYLEN:
                begin
                    pay_len_next = b;
                    count_next   = 8'h00;
                    phase_next   = id_present_reg ? PH_IDLEN : PH_TYPE;
                end
                PH_IDLEN:
                begin
                    id_len_next = b;
                    count_next  = 8'h00;
                    phase_next  = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_ok_next = type_ok_now;
                    if (count_inc < {1'b0, type_len_reg})
                    begin
                        count_next = count_inc[7:0];
                    end
                    else if (!type_ok_now)
                    begin
                        phase_next = PH_IDLE;
                        fire       = 1'b1;
                        status     = nsrp_pkg::ST_BAD_TYPE;
                    end
                    else if (id_present_reg && id_len_reg != 8'h00)
                    begin
                        count_next = 8'h00;
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        count_next = 8'h00;
                        if (pay_len_reg == 8'h00)
                        begin
                            phase_next = PH_IDLE;
                            fire       = 1'b1;
                            status     = nsrp_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_ID:
                begin
                    if (count_inc < {1'b0, id_len_reg})
                    begin
                        count_next = count_inc[7:0];
                    end
                    else
                    begin
                        count_next = 8'h00;
                        if (pay_len_reg == 8'h00)
                        begin
                            phase_next = PH_IDLE;
                            fire       = 1'b1;
                            status     = nsrp_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    fire     = 1'b1;
                    out_byte = b;
                    last     = (count_inc >= {1'b0, pay_len_reg});
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        count_next = count_inc[7:0];
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign res.fire                = fire;
    assign res.data.payload_byte   = out_byte;
    assign res.data.payload_last   = last;
    assign res.data.message_end    = end_flag_next;
    assign res.data.payload_length = pay_len_next;
    assign res.data.status         = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tnf_reg        <= 3'd0;
            id_present_reg <= 1'b0;
            end_flag_reg   <= 1'b0;
            type_len_reg   <= 8'h00;
            pay_len_reg    <= 8'h00;
            id_len_reg     <= 8'h00;
            count_reg      <= 8'h00;
            type_ok_reg    <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            tnf_reg        <= tnf_next;
            id_present_reg <= id_present_next;
            end_flag_reg   <= end_flag_next;
            type_len_reg   <= type_len_next;
            pay_len_reg    <= pay_len_next;
            id_len_reg     <= id_len_next;
            count_reg      <= count_next;
            type_ok_reg    <= type_ok_next;
        end
    end

endmodule

>>> rtl/core/nsrp_out_stage.sv
// Result register of the NDEF short record text parser.
// Loads a formed result and holds it until the consumer takes it.
// Depends on nsrp_pkg.
module nsrp_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  nsrp_pkg::res_ctl_t res,
    output logic               slot_free,
    output logic               result_valid,
    input  logic               result_ready,
    output nsrp_pkg::result_t  result
);

    logic              out_valid_reg;
    logic              out_valid_next;
    nsrp_pkg::result_t out_data_reg;

    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.fire;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.fire)
        begin
            out_data_reg <= res.data;
        end
    end

endmodule

>>> rtl/core/ndef_short_record_text_parser.sv
// Top level of the NDEF short record text parser: input register, parse logic, result register.
// Depends on nsrp_pkg, nsrp_in_stage, nsrp_parser and nsrp_out_stage.
//
// The block takes one record byte per cycle while the result side does not stall,
// and gives at most one result per byte. A byte passes through an input register
// and the parse state machine into a result register. result_valid rises when the
// result register loads the byte's result; the byte waits in the input register
// while the result slot is held. The parser updates its state as each byte advances.
// Bytes that produce no result (most header, length, type and ID bytes) still advance
// in turn. Result-side backpressure stalls the input only when both registers are full.
module ndef_short_record_text_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  nsrp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output nsrp_pkg::result_t result
);

    logic               slot_free;
    logic               advance;
    nsrp_pkg::item_t    held;
    nsrp_pkg::res_ctl_t res;

    nsrp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .slot_free  (slot_free),
        .advance    (advance),
        .held       (held)
    );

    nsrp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .held    (held),
        .res     (res)
    );

    nsrp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .res          (res),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> rtl/core/nsrp_checker.sv
// Port checker for the NDEF short record text parser, bound to the top level.
// Depends on nsrp_pkg and ndef_short_record_text_parser.
module nsrp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input nsrp_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != nsrp_pkg::ST_DATA |-> result.payload_last)
        else $error("status result without last mark");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != nsrp_pkg::ST_DATA |-> result.payload_byte == 8'h00)
        else $error("status result carries a payload byte");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid || result_ready |-> item_ready)
        else $error("request refused while result slot is free");

endmodule

bind ndef_short_record_text_parser nsrp_checker u_nsrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
